[rtl/apmm_pkg.sv]
// shared types, register indexes and command codes of the attitude pid motor mixer
package apmm_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_MOTORS = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IDX_W      = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAINS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAINS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_GAINS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMITS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_SCALES    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_OFFSETS   = 3'd6;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP,
        MUL_KD,
        MUL_KI,
        MUL_SCALE
    } mul_sel_t;

    // what happens to the registered product
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_INTEG,
        ACC_DRIVE,
        ACC_MOTOR
    } acc_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic             load_in;
        logic             publish;
        mul_sel_t         mul_sel;
        logic [IDX_W-1:0] mul_idx;
        acc_op_t          acc_op;
        logic [IDX_W-1:0] acc_idx;
        logic             mix_en;
        logic [IDX_W-1:0] mix_idx;
    } cmd_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [NUM_AXES-1:0][47:0]   gains;
        logic [31:0]                 int_limits;
        logic [31:0]                 pwm_limits;
        logic [NUM_MOTORS-1:0][11:0] scales;
        logic [NUM_MOTORS-1:0][11:0] offsets;
    } cfg_t;

endpackage

[rtl/attitude_pid_motor_mixer_unit.sv]
// top level of the attitude pid motor mixer
// out_valid rises after the 19 steps, once the flush state publishes the result
// in_stall holds off new input beats until then; all steps share one 19x17 multiplier
// a new input beat is taken while the previous result still waits in the output registers
// reset: rst_n clears all configuration to zero, the integral and previous angle of
// every axis to zero, and leaves no result pending
module attitude_pid_motor_mixer_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [15:0]               goal_pitch,
    input  logic signed [15:0]               goal_roll,
    input  logic signed [15:0]               goal_yaw,
    input  logic signed [15:0]               angle_pitch,
    input  logic signed [15:0]               angle_roll,
    input  logic signed [15:0]               angle_yaw,
    input  logic        [15:0]               throttle_bias,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic        [15:0]               motor_0,
    output logic        [15:0]               motor_1,
    output logic        [15:0]               motor_2,
    output logic        [15:0]               motor_3,
    output logic signed [15:0]               pitch_drive,
    output logic signed [15:0]               roll_drive,
    output logic signed [15:0]               yaw_drive,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [apmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [apmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    apmm_pkg::cmd_t cmd;
    apmm_pkg::cfg_t cfg;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    apmm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    apmm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    apmm_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .goal_pitch    (goal_pitch),
        .goal_roll     (goal_roll),
        .goal_yaw      (goal_yaw),
        .angle_pitch   (angle_pitch),
        .angle_roll    (angle_roll),
        .angle_yaw     (angle_yaw),
        .throttle_bias (throttle_bias),
        .motor_0       (motor_0),
        .motor_1       (motor_1),
        .motor_2       (motor_2),
        .motor_3       (motor_3),
        .pitch_drive   (pitch_drive),
        .roll_drive    (roll_drive),
        .yaw_drive     (yaw_drive)
    );

endmodule

[rtl/apmm_cfg_regs.sv]
// configuration register file with index decode
module apmm_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [apmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [apmm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output apmm_pkg::cfg_t                   cfg
);

    logic [47:0] pitch_gains_reg;
    logic [47:0] roll_gains_reg;
    logic [47:0] yaw_gains_reg;
    logic [31:0] int_limits_reg;
    logic [31:0] pwm_limits_reg;
    logic [47:0] scales_reg;
    logic [47:0] offsets_reg;

    // register writes, out of range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_gains_reg <= '0;
            roll_gains_reg  <= '0;
            yaw_gains_reg   <= '0;
            int_limits_reg  <= '0;
            pwm_limits_reg  <= '0;
            scales_reg      <= '0;
            offsets_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                apmm_pkg::REG_PITCH_GAINS:     pitch_gains_reg <= cfg_data;
                apmm_pkg::REG_ROLL_GAINS:      roll_gains_reg  <= cfg_data;
                apmm_pkg::REG_YAW_GAINS:       yaw_gains_reg   <= cfg_data;
                apmm_pkg::REG_INTEGRAL_LIMITS: int_limits_reg  <= cfg_data[31:0];
                apmm_pkg::REG_PWM_LIMITS:      pwm_limits_reg  <= cfg_data[31:0];
                apmm_pkg::REG_MOTOR_SCALES:    scales_reg      <= cfg_data;
                apmm_pkg::REG_MOTOR_OFFSETS:   offsets_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // pack for the datapath
    always_comb
    begin
        cfg.gains[0]   = pitch_gains_reg;
        cfg.gains[1]   = roll_gains_reg;
        cfg.gains[2]   = yaw_gains_reg;
        cfg.int_limits = int_limits_reg;
        cfg.pwm_limits = pwm_limits_reg;
        cfg.scales     = scales_reg;
        cfg.offsets    = offsets_reg;
    end

endmodule

[rtl/apmm_ctrl.sv]
// step sequencer and handshake control of the attitude pid motor mixer
module apmm_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output apmm_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    // each axis takes four steps, the mixer starts after the last drive step
    localparam logic [4:0] MIX_FIRST = 5'(apmm_pkg::NUM_AXES * 4 + 1);
    localparam logic [4:0] LAST_STEP = 5'(apmm_pkg::NUM_AXES * 4 + apmm_pkg::NUM_MOTORS + 2);
    localparam logic [1:0] PH_P   = 2'd0;
    localparam logic [1:0] PH_D   = 2'd1;
    localparam logic [1:0] PH_I   = 2'd2;
    localparam logic [1:0] PH_INT = 2'd3;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       publish;
    logic [2:0] axis_idx;
    logic [2:0] axis_prev;
    logic [1:0] phase;
    logic [4:0] mix_pos;
    logic [4:0] mul_pos;
    logic [4:0] acc_pos;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign publish   = (state_reg == ST_FLUSH) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (publish)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_FLUSH:
            begin
                if (publish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // step decode
    assign axis_idx  = step_reg[4:2];
    assign axis_prev = axis_idx - 3'd1;
    assign phase     = step_reg[1:0];
    assign mix_pos   = step_reg - MIX_FIRST;
    assign mul_pos   = mix_pos - 5'd1;
    assign acc_pos   = mix_pos - 5'd2;

    always_comb
    begin
        cmd.load_in = accept;
        cmd.publish = publish;
        cmd.mul_sel = apmm_pkg::MUL_NONE;
        cmd.mul_idx = '0;
        cmd.acc_op  = apmm_pkg::ACC_NONE;
        cmd.acc_idx = '0;
        cmd.mix_en  = 1'b0;
        cmd.mix_idx = '0;
        if (state_reg == ST_RUN)
        begin
            if (step_reg < MIX_FIRST)
            begin
                // pid steps, the drive of one axis overlaps the next axis
                case (phase)
                    PH_P:
                    begin
                        if (axis_idx < 3'(apmm_pkg::NUM_AXES))
                        begin
                            cmd.mul_sel = apmm_pkg::MUL_KP;
                            cmd.mul_idx = axis_idx[1:0];
                        end
                        if (axis_idx != 3'd0)
                        begin
                            cmd.acc_op  = apmm_pkg::ACC_DRIVE;
                            cmd.acc_idx = axis_prev[1:0];
                        end
                    end
                    PH_D:
                    begin
                        cmd.mul_sel = apmm_pkg::MUL_KD;
                        cmd.mul_idx = axis_idx[1:0];
                        cmd.acc_op  = apmm_pkg::ACC_LOAD;
                        cmd.acc_idx = axis_idx[1:0];
                    end
                    PH_I:
                    begin
                        cmd.mul_sel = apmm_pkg::MUL_KI;
                        cmd.mul_idx = axis_idx[1:0];
                        cmd.acc_op  = apmm_pkg::ACC_ADD;
                        cmd.acc_idx = axis_idx[1:0];
                    end
                    PH_INT:
                    begin
                        cmd.acc_op  = apmm_pkg::ACC_INTEG;
                        cmd.acc_idx = axis_idx[1:0];
                    end
                    default: ;
                endcase
            end
            else
            begin
                // mixer pipeline: mix, scale, finish per motor
                if (mix_pos < 5'(apmm_pkg::NUM_MOTORS))
                begin
                    cmd.mix_en  = 1'b1;
                    cmd.mix_idx = mix_pos[1:0];
                end
                if ((mix_pos >= 5'd1) && (mix_pos <= 5'(apmm_pkg::NUM_MOTORS)))
                begin
                    cmd.mul_sel = apmm_pkg::MUL_SCALE;
                    cmd.mul_idx = mul_pos[1:0];
                end
                if (mix_pos >= 5'd2)
                begin
                    cmd.acc_op  = apmm_pkg::ACC_MOTOR;
                    cmd.acc_idx = acc_pos[1:0];
                end
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/apmm_datapath.sv]
// pid and mixer datapath around one shared multiplier
module apmm_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  apmm_pkg::cmd_t     cmd,
    input  apmm_pkg::cfg_t     cfg,
    input  logic signed [15:0] goal_pitch,
    input  logic signed [15:0] goal_roll,
    input  logic signed [15:0] goal_yaw,
    input  logic signed [15:0] angle_pitch,
    input  logic signed [15:0] angle_roll,
    input  logic signed [15:0] angle_yaw,
    input  logic        [15:0] throttle_bias,
    output logic        [15:0] motor_0,
    output logic        [15:0] motor_1,
    output logic        [15:0] motor_2,
    output logic        [15:0] motor_3,
    output logic signed [15:0] pitch_drive,
    output logic signed [15:0] roll_drive,
    output logic signed [15:0] yaw_drive
);

    // mixing signs, bit k set when the drive adds to motor k
    localparam logic [3:0] PITCH_POS = 4'b1001;
    localparam logic [3:0] ROLL_POS  = 4'b0011;
    localparam logic [3:0] YAW_POS   = 4'b0101;

    logic signed [15:0] goal_reg   [apmm_pkg::NUM_AXES];
    logic signed [15:0] angle_reg  [apmm_pkg::NUM_AXES];
    logic signed [15:0] integ_reg  [apmm_pkg::NUM_AXES];
    logic signed [15:0] prev_reg   [apmm_pkg::NUM_AXES];
    logic signed [15:0] drive_reg  [apmm_pkg::NUM_AXES];
    logic        [15:0] motor_reg  [apmm_pkg::NUM_MOTORS];
    logic        [15:0] throttle_reg;
    logic signed [35:0] prod_reg;
    logic signed [35:0] sum_reg;
    logic signed [18:0] mix_reg;
    logic        [15:0] out_motor_reg [apmm_pkg::NUM_MOTORS];
    logic signed [15:0] out_drive_reg [apmm_pkg::NUM_AXES];

    logic signed [16:0] err;
    logic signed [16:0] fall;
    logic        [47:0] gains;
    logic signed [18:0] op_a;
    logic signed [16:0] op_b;
    logic signed [35:0] mult;
    logic signed [35:0] rnd_i;
    logic signed [21:0] isum;
    logic signed [21:0] ilo;
    logic signed [21:0] ihi;
    logic signed [21:0] iclamp;
    logic signed [21:0] dsum;
    logic signed [15:0] dsat;
    logic signed [18:0] mix_val;
    logic signed [18:0] t_pitch;
    logic signed [18:0] t_roll;
    logic signed [18:0] t_yaw;
    logic signed [35:0] rnd_s;
    logic signed [27:0] msum;
    logic signed [27:0] pmin_w;
    logic signed [27:0] pmax_w;
    logic signed [27:0] mclamp;
    logic        [11:0] offs;

    // multiplier operands
    assign gains = cfg.gains[cmd.mul_idx];
    assign err   = 17'(goal_reg[cmd.mul_idx]) - 17'(angle_reg[cmd.mul_idx]);
    assign fall  = 17'(prev_reg[cmd.mul_idx]) - 17'(angle_reg[cmd.mul_idx]);

    always_comb
    begin
        case (cmd.mul_sel)
            apmm_pkg::MUL_KP:
            begin
                op_a = 19'(err);
                op_b = 17'(signed'(gains[15:0]));
            end
            apmm_pkg::MUL_KI:
            begin
                op_a = 19'(err);
                op_b = 17'(signed'(gains[31:16]));
            end
            apmm_pkg::MUL_KD:
            begin
                op_a = 19'(fall);
                op_b = 17'(signed'(gains[47:32]));
            end
            apmm_pkg::MUL_SCALE:
            begin
                op_a = mix_reg;
                op_b = signed'({5'b0, cfg.scales[cmd.mul_idx]});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mult = op_a * op_b;

    // integral update with clamp, upper limit wins when reversed
    assign rnd_i = prod_reg + 36'sd8192;
    assign isum  = 22'(integ_reg[cmd.acc_idx]) + rnd_i[35:14];
    assign ilo   = 22'(signed'(cfg.int_limits[15:0]));
    assign ihi   = 22'(signed'(cfg.int_limits[31:16]));

    always_comb
    begin
        iclamp = isum;
        if (iclamp < ilo)
        begin
            iclamp = ilo;
        end
        if (iclamp > ihi)
        begin
            iclamp = ihi;
        end
    end

    // drive, rounding offset already sits in the sum
    assign dsum = sum_reg[35:14] + 22'(integ_reg[cmd.acc_idx]);

    always_comb
    begin
        if (dsum > 22'sd32767)
        begin
            dsat = 16'sh7fff;
        end
        else if (dsum < -22'sd32768)
        begin
            dsat = 16'sh8000;
        end
        else
        begin
            dsat = dsum[15:0];
        end
    end

    // x pattern mix on top of the minimum pwm
    assign t_pitch = PITCH_POS[cmd.mix_idx] ? 19'(drive_reg[0]) : -19'(drive_reg[0]);
    assign t_roll  = ROLL_POS[cmd.mix_idx]  ? 19'(drive_reg[1]) : -19'(drive_reg[1]);
    assign t_yaw   = YAW_POS[cmd.mix_idx]   ? 19'(drive_reg[2]) : -19'(drive_reg[2]);
    assign mix_val = signed'({3'b0, cfg.pwm_limits[15:0]}) + t_pitch + t_roll + t_yaw;

    // scaled motor value, bias, offset and pwm clamp
    assign offs   = cfg.offsets[cmd.acc_idx];
    assign rnd_s  = prod_reg + 36'sd128;
    assign pmin_w = signed'({12'b0, cfg.pwm_limits[15:0]});
    assign pmax_w = signed'({12'b0, cfg.pwm_limits[31:16]});
    assign msum   = rnd_s[35:8] + signed'({12'b0, throttle_reg}) + 28'(signed'(offs));

    always_comb
    begin
        mclamp = msum;
        if (mclamp < pmin_w)
        begin
            mclamp = pmin_w;
        end
        if (mclamp > pmax_w)
        begin
            mclamp = pmax_w;
        end
    end

    // controller state kept across ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apmm_pkg::NUM_AXES; i++)
            begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else if (cmd.acc_op == apmm_pkg::ACC_INTEG)
        begin
            integ_reg[cmd.acc_idx] <= iclamp[15:0];
            prev_reg[cmd.acc_idx]  <= angle_reg[cmd.acc_idx];
        end
    end

    // input capture, product, accumulator and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            goal_reg[0]  <= goal_pitch;
            goal_reg[1]  <= goal_roll;
            goal_reg[2]  <= goal_yaw;
            angle_reg[0] <= angle_pitch;
            angle_reg[1] <= angle_roll;
            angle_reg[2] <= angle_yaw;
            throttle_reg <= throttle_bias;
        end
        prod_reg <= mult;
        case (cmd.acc_op)
            apmm_pkg::ACC_LOAD:  sum_reg <= prod_reg + 36'sd8192;
            apmm_pkg::ACC_ADD:   sum_reg <= sum_reg + prod_reg;
            apmm_pkg::ACC_DRIVE: drive_reg[cmd.acc_idx] <= dsat;
            apmm_pkg::ACC_MOTOR: motor_reg[cmd.acc_idx] <= mclamp[15:0];
            default: ;
        endcase
        if (cmd.mix_en)
        begin
            mix_reg <= mix_val;
        end
    end

    // output beat registers
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            for (int k = 0; k < apmm_pkg::NUM_MOTORS; k++)
            begin
                out_motor_reg[k] <= motor_reg[k];
            end
            for (int i = 0; i < apmm_pkg::NUM_AXES; i++)
            begin
                out_drive_reg[i] <= drive_reg[i];
            end
        end
    end

    assign motor_0     = out_motor_reg[0];
    assign motor_1     = out_motor_reg[1];
    assign motor_2     = out_motor_reg[2];
    assign motor_3     = out_motor_reg[3];
    assign pitch_drive = out_drive_reg[0];
    assign roll_drive  = out_drive_reg[1];
    assign yaw_drive   = out_drive_reg[2];

endmodule
